FILE: rtl/rwm_pkg.sv
package rwm_pkg;

  // Width and reset value of the window length register.
  localparam int unsigned CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd3;

  // Cells per group in the first level of the read tree.
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned GROUP_BITS = 3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } rwm_state_e;

endpackage

FILE: rtl/rwm_cell.sv
module rwm_cell #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           sample_present_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_min_i,
  input  logic                           prev_present_i,
  output logic signed [SAMPLE_WIDTH-1:0] min_o,
  output logic                           present_o
);

  logic signed [SAMPLE_WIDTH-1:0] min_q, min_d;
  logic                           present_q, present_d;
  logic                           take_new;

  // Minimum over the newest samples: the new one against what the neighbor held.
  always_comb begin
    take_new  = sample_present_i && (!prev_present_i || (sample_i < prev_min_i));
    min_d     = take_new ? sample_i : prev_min_i;
    present_d = sample_present_i || prev_present_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else if (shift_i) begin
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      min_q <= min_d;
    end
  end

  assign min_o     = min_q;
  assign present_o = present_q;

endmodule

FILE: rtl/rwm_select.sv
module rwm_select import rwm_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] index_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        cell_min_i [MAX_WINDOW],
  input  logic                                  cell_present_i [MAX_WINDOW],
  output logic signed [SAMPLE_WIDTH-1:0]        min_o,
  output logic                                  present_o
);

  localparam int NG = (MAX_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int HW = (NG > 1) ? $clog2(NG) : 1;

  logic [GROUP_BITS-1:0]          lo;
  logic [HW-1:0]                  hi_d, hi_q;
  logic signed [SAMPLE_WIDTH-1:0] grp_min_d [NG];
  logic signed [SAMPLE_WIDTH-1:0] grp_min_q [NG];
  logic                           grp_pres_d [NG];
  logic                           grp_pres_q [NG];

  assign lo   = GROUP_BITS'(index_i);
  assign hi_d = HW'(index_i >> GROUP_BITS);

  // First level: pick one cell in every group by the low index bits.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_min_d[g]  = '0;
      grp_pres_d[g] = 1'b0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if ((g * GROUP_SIZE + k < MAX_WINDOW) && (lo == GROUP_BITS'(k))) begin
          grp_min_d[g]  = cell_min_i[g * GROUP_SIZE + k];
          grp_pres_d[g] = cell_present_i[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hi_q <= hi_d;
      for (int g = 0; g < NG; g++) begin
        grp_min_q[g]  <= grp_min_d[g];
        grp_pres_q[g] <= grp_pres_d[g];
      end
    end
  end

  // Second level: pick the group.
  assign min_o     = grp_min_q[hi_q];
  assign present_o = grp_pres_q[hi_q];

endmodule

FILE: rtl/running_window_minimum.sv
// A result is registered in the group registers of the two-level read tree, then in the
// output register once that is free. A sample is taken only in idle, so none is taken
// before the results of the last one are emitted; the last sample of a series flushes
// n results (n at most MAX_WINDOW/2 + 1), each a read of one cell.
// Reset: fill count cleared, window length 3, output empty; cells need no clearing pass.
module running_window_minimum import rwm_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [CFG_WIDTH-1:0]           cfg_wdata_i,
  // sample requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           sample_present_i,
  input  logic                           last_i,
  // result requests
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_min_o,
  output logic                           min_present_o,
  output logic                           last_result_o
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  // Every result is the minimum over the newest m samples of the series, with
  // m = min(d + behind + 1, fill). Cell i of the chain holds exactly that minimum
  // for m = i + 1, so a result is a read of one cell.

  rwm_state_e state_q, state_d;

  logic [CFG_WIDTH-1:0] wlen_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        dist_q, dist_d;
  logic                 flush_q, flush_d;

  logic [LW-1:0] wlen_ext, wlen_clip;
  logic [CW-1:0] wlen, half, behind;
  logic [CW-1:0] fill_inc, fill_inc_m1, fill_m1, reach, tap;
  logic          accept, rd_load, out_load, out_free, fin;

  logic signed [SAMPLE_WIDTH-1:0] cell_min  [MAX_WINDOW];
  logic                           cell_pres [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] sel_min;
  logic                           sel_pres;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] win_min_q;
  logic                           min_pres_q, last_res_q;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      wlen_q <= cfg_wdata_i;
    end
  end

  // Clamp the window to 1 .. MAX_WINDOW and split it around the center.
  always_comb begin
    wlen_ext = LW'(wlen_q);
    if (wlen_ext == '0) begin
      wlen_clip = LW'(1);
    end else if (wlen_ext > LW'(MAX_WINDOW)) begin
      wlen_clip = LW'(MAX_WINDOW);
    end else begin
      wlen_clip = wlen_ext;
    end
    wlen   = CW'(wlen_clip);
    half   = wlen >> 1;
    behind = wlen - CW'(1) - half;
  end

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign fill_inc    = (fill_q < CW'(MAX_WINDOW)) ? fill_q + CW'(1) : fill_q;
  assign fill_inc_m1 = fill_inc - CW'(1);
  assign fill_m1     = fill_q - CW'(1);
  // Far end of the window, clipped to the start of the series.
  assign reach       = dist_q + behind;
  assign tap         = (reach < fill_m1) ? reach : fill_m1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fin         = flush_q && (dist_q == '0);

  // Sequencer: take a sample, then read one cell per owed result.
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    dist_d   = dist_q;
    flush_d  = flush_q;
    rd_load  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fill_d  = fill_inc;
          flush_d = last_i;
          if (last_i) begin
            // Flush: the result at the center first, then the ones ahead of it.
            dist_d  = (half < fill_inc_m1) ? half : fill_inc_m1;
            state_d = S_READ;
          end else if (fill_inc > half) begin
            dist_d  = half;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_load = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (flush_q && (dist_q != '0)) begin
            dist_d  = dist_q - CW'(1);
            state_d = S_READ;
          end else begin
            // End of series: drop the history by clearing the fill count.
            if (flush_q) begin
              fill_d = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      dist_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      dist_q  <= dist_d;
      flush_q <= flush_d;
    end
  end

  // Cell chain: advance every cell on each accepted sample.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] prev_min;
    logic                           prev_pres;
    if (i == 0) begin : g_head
      assign prev_min  = '0;
      assign prev_pres = 1'b0;
    end else begin : g_link
      assign prev_min  = cell_min[i-1];
      assign prev_pres = cell_pres[i-1];
    end
    rwm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .shift_i         (accept),
      .sample_i        (sample_i),
      .sample_present_i(sample_present_i),
      .prev_min_i      (prev_min),
      .prev_present_i  (prev_pres),
      .min_o           (cell_min[i]),
      .present_o       (cell_pres[i])
    );
  end

  rwm_select #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_select (
    .clk_i         (clk_i),
    .load_i        (rd_load),
    .index_i       (IW'(tap)),
    .cell_min_i    (cell_min),
    .cell_present_i(cell_pres),
    .min_o         (sel_min),
    .present_o     (sel_pres)
  );

  // Output register: hold a result until taken while the next sample comes in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      win_min_q  <= sel_pres ? sel_min : '0;
      min_pres_q <= sel_pres;
      last_res_q <= fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_min_o  = win_min_q;
  assign min_present_o = min_pres_q;
  assign last_result_o = last_res_q;

`ifndef ASSERT_OFF
  a_last_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (state_q == S_READ))
    else $error("last sample did not start a flush");

  a_read_has_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (fill_q != '0))
    else $error("cell read with empty history");

  a_dist_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (dist_q <= half))
    else $error("result position beyond half window");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && fin) |=> ((fill_q == '0) && (state_q == S_IDLE)))
    else $error("series end did not clear history");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
  import rwm_pkg::*;

  localparam int MAX_WIN      = 64;
  localparam int SETTLE       = 8;       // cycles for a sample that owes no result to finish
  localparam int DRAIN        = 40;
  localparam int RANDOM_ITEMS = 250;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               present;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] window_min;
    logic               min_present;
    logic               last_result;
  } result_t;

  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_WIDTH-1:0] win;
    logic [31:0]          value;
    logic                 present;
    logic                 last;
    logic                 typed;
    result_t              expected;
  } row_t;

  localparam result_t NO_RESULT = '0;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_WIDTH-1:0]  cfg_wdata_i      = '0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic signed [31:0]    sample_i         = '0;
  logic                  sample_present_i = 1'b0;
  logic                  last_i           = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic signed [31:0]    window_min_o;
  logic                  min_present_o;
  logic                  last_result_o;

  // Mirror of the block: sample cells, series fill and window length.
  cell_t                history [MAX_WIN];
  int unsigned          fill_count = 0;
  int unsigned          write_pos  = 0;
  logic [CFG_WIDTH-1:0] window_cfg = WINDOW_RESET;

  result_t owed_q[$];    // minima still owed by the block, oldest first
  result_t staged_q[$];  // minima caused by the latest sample
  int      fails  = 0;
  int      cycles = 0;
  int      stall_left = 0;
  logic    quiet = 1'b0;

  running_window_minimum dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .sample_present_i (sample_present_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .window_min_o     (window_min_o),
    .min_present_o    (min_present_o),
    .last_result_o    (last_result_o)
  );

  always #6 clk_i = ~clk_i;

  // Directed table: extremes, missing samples, short series, window length zero and
  // above the maximum, and a window change in the middle of a series.
  row_t plan [30] = '{
    '{ROW_SAMPLE, 7'd0,   32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h8000_0000, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0005, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, NO_RESULT},
    // one-sample series: its own value, marked last
    '{ROW_SAMPLE, 7'd0,   32'h1234_5678, 1'b1, 1'b1, 1'b1, '{32'h1234_5678, 1'b1, 1'b1}},
    // zero length acts as one: every sample is its own minimum
    '{ROW_WINDOW, 7'd0,   32'h0,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h8000_0000, 1'b1, 1'b0, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
    '{ROW_SAMPLE, 7'd0,   32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{ROW_SAMPLE, 7'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '{32'h0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0007, 1'b1, 1'b1, 1'b1, '{32'h7, 1'b1, 1'b1}},
    '{ROW_WINDOW, 7'd1,   32'h0,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1, '{32'h0, 1'b0, 1'b1}},
    // widest window, series too short to emit before its end
    '{ROW_WINDOW, 7'd64,  32'h0,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'hFFFF_FFFD, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0064, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h5555_5555, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0002, 1'b1, 1'b1, 1'b0, NO_RESULT},
    // length above the maximum saturates; windows with nothing present
    '{ROW_WINDOW, 7'd127, 32'h0,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0011, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h8000_0001, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h7FFF_FFFE, 1'b0, 1'b1, 1'b0, NO_RESULT},
    // change the length in the middle of a series
    '{ROW_WINDOW, 7'd5,   32'h0,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0009, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'hFFFF_FFF7, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0004, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WINDOW, 7'd2,   32'h0,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0001, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, 7'd0,   32'h0000_0000, 1'b1, 1'b1, 1'b0, NO_RESULT}
  };

  // Stage the minimum for the position d samples behind the newest one.
  function automatic void window_min_at(int unsigned d, int unsigned k2,
                                        int unsigned behind, logic fin);
    int unsigned        lo, hi, age, idx;
    logic               have;
    logic signed [31:0] best;
    result_t            res;
    lo   = (d > k2) ? d - k2 : 0;
    hi   = d + behind;
    have = 1'b0;
    best = '0;
    if (hi > fill_count - 1) hi = fill_count - 1;
    for (age = lo; age <= hi; age++) begin
      idx = (write_pos + MAX_WIN - 1 - (age % MAX_WIN)) % MAX_WIN;
      if (history[idx].present && (!have || history[idx].value < best)) begin
        best = history[idx].value;
        have = 1'b1;
      end
    end
    res.window_min  = have ? best : '0;
    res.min_present = have;
    res.last_result = fin;
    staged_q = {staged_q, res};
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_window();
    case ($urandom_range(9, 0))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(127, 65));
      4: return 7'd63;
      5: return 7'($urandom_range(12, 2));
      default: return 7'(2 * $urandom_range(7, 1) + 1);
    endcase
  endfunction

  // Offer one sample request, hold it until accepted, then predict what it owes.
  task automatic push_sample(input logic [31:0] value, input logic present,
                             input logic last, input logic typed, input result_t typed_res);
    int unsigned w, k2, behind;
    int          pos;
    in_valid_i       <= 1'b1;
    sample_i         <= value;
    sample_present_i <= present;
    last_i           <= last;
    do @(posedge clk_i); while (!in_ready_o);

    w = window_cfg;
    if (w == 0) w = 1;
    if (w > MAX_WIN) w = MAX_WIN;
    k2     = w / 2;
    behind = w - 1 - k2;
    history[write_pos].value   = value;
    history[write_pos].present = present;
    write_pos = (write_pos + 1) % MAX_WIN;
    if (fill_count < MAX_WIN) fill_count++;
    staged_q.delete();
    if (!last) begin
      if (fill_count > k2) window_min_at(k2, k2, behind, 1'b0);
    end else begin
      // flush every position still owed, oldest first
      for (pos = (k2 < fill_count - 1) ? k2 : fill_count - 1; pos >= 0; pos--)
        window_min_at(pos, k2, behind, pos == 0);
      foreach (history[i]) history[i].present = 1'b0;
      fill_count = 0;
      write_pos  = 0;
    end

    if (typed) begin
      if (staged_q.size() != 1) begin
        $error("directed row owes %0d minima instead of one", staged_q.size());
        fails++;
      end
      owed_q = {owed_q, typed_res};
    end else begin
      foreach (staged_q[i]) owed_q = {owed_q, staged_q[i]};
    end
  endtask

  task automatic sender_gap(input logic burst);
    int n, pick;
    n = 0;
    if (!burst) begin
      pick = $urandom_range(99, 0);
      if (pick >= 90) n = $urandom_range(30, 5);
      else if (pick >= 55) n = $urandom_range(3, 1);
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drain the block, let it settle, then write the window length.
  task automatic set_window(input logic [CFG_WIDTH-1:0] len);
    in_valid_i <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    window_cfg = len;
  endtask

  // Result side: random stalls, with quiet stretches, and the scoreboard check.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: window_min %0d", window_min_o);
          fails++;
        end else begin
          result_t want;
          want = owed_q.pop_front();
          if (window_min_o !== want.window_min) begin
            $error("window_min: expected %0d, got %0d", want.window_min, window_min_o);
            fails++;
          end
          if (min_present_o !== want.min_present) begin
            $error("min_present: expected %0d, got %0d", want.min_present, min_present_o);
            fails++;
          end
          if (last_result_o !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, last_result_o);
            fails++;
          end
        end
      end
      if ($urandom_range(199, 0) == 0) quiet = ~quiet;
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(99, 0) < 25) begin
        stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 0);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned sent, len, k, pick;
    logic        burst, present;
    logic [31:0] value;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WINDOW) begin
        set_window(plan[i].win);
      end else begin
        push_sample(plan[i].value, plan[i].present, plan[i].last, plan[i].typed,
                    plan[i].expected);
        sender_gap(1'b0);
      end
    end

    // Random series, mostly short, a few long enough to wrap the sample store.
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99, 0) < 35) set_window(pick_window());
      pick = $urandom_range(99, 0);
      if (pick < 65) len = $urandom_range(12, 1);
      else if (pick < 90) len = $urandom_range(40, 13);
      else len = $urandom_range(100, 41);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      burst = ($urandom_range(3, 0) == 0);
      for (k = 0; k < len; k++) begin
        if (k != 0 && $urandom_range(99, 0) < 2) set_window(pick_window());
        case ($urandom_range(9, 0))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
          3, 4, 5: value = 32'(int'($urandom_range(40, 0)) - 20);
          default: value = $urandom;
        endcase
        present = ($urandom_range(99, 0) < 85);
        push_sample(value, present, k == len - 1, 1'b0, NO_RESULT);
        sender_gap(burst);
      end
      sent += len;
    end

    in_valid_i <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (fails == 0 && owed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rwm_pkg.sv
rtl/rwm_cell.sv
rtl/rwm_select.sv
rtl/running_window_minimum.sv
test/tb_top.sv
